>>> sv/ple_pkg.sv
`default_nettype none
package ple_pkg;

	// indices and lengths up to 64 cells
	localparam int IDX_W = 7;
	localparam int VAL_W = 32;
	localparam int POS_W = 6;

	typedef enum logic [1:0] {
		REQ_INSERT  = 2'd0,
		REQ_DELETE  = 2'd1,
		REQ_REVERSE = 2'd2,
		REQ_READ    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_BAD  = 2'd1,
		STAT_FULL = 2'd2
	} stat_t;

	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_INS,
		CMD_DEL,
		CMD_ROT_FWD,
		CMD_ROT_BACK
	} cell_op_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	typedef struct packed {
		cell_op_t         op;
		logic [IDX_W-1:0] pos;   // physical cell of the edit
		logic [IDX_W-1:0] last;  // physical index of the last live cell
	} cell_cmd_t;

endpackage
`default_nettype wire

>>> sv/ple_cell.sv
`default_nettype none
module ple_cell #(
	parameter int IDX = 0
) (
	input  wire                    clk,
	input  wire ple_pkg::cell_cmd_t cmd,
	input  wire [ple_pkg::VAL_W-1:0] new_val,
	input  wire [ple_pkg::VAL_W-1:0] left_val,
	input  wire [ple_pkg::VAL_W-1:0] right_val,
	input  wire [ple_pkg::VAL_W-1:0] head_val,
	input  wire [ple_pkg::VAL_W-1:0] tail_val,
	output logic [ple_pkg::VAL_W-1:0] val
);
	import ple_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic [VAL_W-1:0] val_q;
	logic [VAL_W-1:0] val_d;

	always_comb begin
		val_d = val_q;
		case (cmd.op)
			CMD_INS: begin
				if (MY_IDX == cmd.pos) begin
					val_d = new_val;
				end else if (MY_IDX > cmd.pos) begin
					val_d = left_val;
				end
			end
			CMD_DEL: begin
				// close the gap from above
				if (MY_IDX >= cmd.pos) begin
					val_d = right_val;
				end
			end
			CMD_ROT_FWD: begin
				if (MY_IDX < cmd.last) begin
					val_d = right_val;
				end else if (MY_IDX == cmd.last) begin
					val_d = head_val;
				end
			end
			CMD_ROT_BACK: begin
				if (MY_IDX == '0) begin
					val_d = tail_val;
				end else if (MY_IDX <= cmd.last) begin
					val_d = left_val;
				end
			end
			default: val_d = val_q;
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

	assign val = val_q;

endmodule
`default_nettype wire

>>> sv/positional_list_engine.sv
`default_nettype none
// Ordered list of up to CAPACITY signed 32-bit values held in a chain of
// cells. Insert, delete and reverse each return one status transaction; they
// are accepted back to back while the output register can take the result.
// Insert and delete shift every cell behind the edit point by one neighbor;
// reverse only flips the orientation flag that maps list positions to cells.
// A read-out occupies the block until its last value is loaded: the chain
// rotates one position per emitted value, so after the last value it is back
// in place, and output stalls stretch the read-out one for one. The store
// holds no defined values after reset; the length resets to zero, so no
// clearing pass is needed.
module positional_list_engine #(
	parameter int CAPACITY = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [39:0] s_axis_tdata,   // position[5:0], new_value[37:6], zero pad
	input  wire  [1:0]  s_axis_tuser,   // req_type[1:0]
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [39:0] m_axis_tdata,   // status[1:0], item_value[33:2], zero pad
	output logic        m_axis_tuser,   // list_empty
	output logic        m_axis_tlast    // last_item
);
	import ple_pkg::*;

	localparam int LEN_W = $clog2(CAPACITY + 1);

	state_t            state_q, state_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [LEN_W-1:0]  cnt_q, cnt_d;
	logic              dir_q, dir_d;
	cell_cmd_t         cmd;

	logic [VAL_W-1:0]  cell_val [CAPACITY];
	logic [VAL_W-1:0]  head_val;
	logic [VAL_W-1:0]  tail_val;

	logic              out_valid_q;
	logic [1:0]        out_status_q;
	logic [VAL_W-1:0]  out_value_q;
	logic              out_empty_q;
	logic              out_last_q;

	logic              out_load;
	stat_t             o_status;
	logic [VAL_W-1:0]  o_value;
	logic              o_empty;
	logic              o_last;

	logic              slot_free;
	logic              in_acc;
	req_t              req;
	logic [POS_W-1:0]  position;
	logic [VAL_W-1:0]  new_value;
	logic [IDX_W-1:0]  pos_x;
	logic [IDX_W-1:0]  len_x;
	logic [LEN_W-1:0]  len_m1;
	logic              full;

	assign req       = req_t'(s_axis_tuser);
	assign position  = s_axis_tdata[POS_W-1:0];
	assign new_value = s_axis_tdata[POS_W+VAL_W-1:POS_W];
	assign pos_x     = IDX_W'(position);
	assign len_x     = IDX_W'(len_q);
	assign len_m1    = len_q - LEN_W'(1);
	assign full      = (len_q == LEN_W'(CAPACITY));

	assign slot_free     = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && slot_free;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// cell chain
	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			logic [VAL_W-1:0] left_v;
			logic [VAL_W-1:0] right_v;
			if (g == 0) begin : g_lft
				assign left_v = new_value;
			end else begin : g_lft
				assign left_v = cell_val[g-1];
			end
			if (g == CAPACITY - 1) begin : g_rgt
				assign right_v = cell_val[g];
			end else begin : g_rgt
				assign right_v = cell_val[g+1];
			end
			ple_cell #(.IDX(g)) u_cell (
				.clk      (clk),
				.cmd      (cmd),
				.new_val  (new_value),
				.left_val (left_v),
				.right_val(right_v),
				.head_val (head_val),
				.tail_val (tail_val),
				.val      (cell_val[g])
			);
		end
	endgenerate

	assign head_val = cell_val[0];

	always_comb begin
		tail_val = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (len_m1 == LEN_W'(i)) begin
				tail_val = tail_val | cell_val[i];
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		len_d    = len_q;
		cnt_d    = cnt_q;
		dir_d    = dir_q;
		cmd.op   = CMD_HOLD;
		cmd.pos  = pos_x;
		cmd.last = IDX_W'(len_m1);
		out_load = 1'b0;
		o_status = STAT_OK;
		o_value  = '0;
		o_empty  = 1'b0;
		o_last   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (req)
						REQ_INSERT: begin
							out_load = 1'b1;
							if (full) begin
								o_status = STAT_FULL;
							end else if (pos_x > len_x) begin
								o_status = STAT_BAD;
							end else begin
								cmd.op  = CMD_INS;
								cmd.pos = dir_q ? (len_x - pos_x) : pos_x;
								len_d   = len_q + LEN_W'(1);
							end
						end
						REQ_DELETE: begin
							out_load = 1'b1;
							if (pos_x >= len_x) begin
								o_status = STAT_BAD;
							end else begin
								cmd.op  = CMD_DEL;
								cmd.pos = dir_q ? (len_x - IDX_W'(1) - pos_x) : pos_x;
								len_d   = len_m1;
							end
						end
						REQ_REVERSE: begin
							out_load = 1'b1;
							if (len_q == '0) begin
								o_status = STAT_BAD;
							end else begin
								dir_d = !dir_q;
							end
						end
						REQ_READ: begin
							if (len_q == '0) begin
								out_load = 1'b1;
								o_empty  = 1'b1;
							end else begin
								state_d = ST_READ;
								cnt_d   = '0;
							end
						end
						default: out_load = 1'b0;
					endcase
				end
			end
			ST_READ: begin
				if (slot_free) begin
					out_load = 1'b1;
					o_value  = dir_q ? tail_val : head_val;
					o_last   = (cnt_q == len_m1);
					cmd.op   = dir_q ? CMD_ROT_BACK : CMD_ROT_FWD;
					if (cnt_q == len_m1) begin
						state_d = ST_IDLE;
						cnt_d   = '0;
					end else begin
						cnt_d = cnt_q + LEN_W'(1);
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			cnt_q       <= '0;
			dir_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			dir_q   <= dir_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the result payload until the next load
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= o_status;
			out_value_q  <= o_value;
			out_empty_q  <= o_empty;
			out_last_q   <= o_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_value_q, out_status_q};
	assign m_axis_tuser  = out_empty_q;
	assign m_axis_tlast  = out_last_q;

	a_no_accept_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> !s_axis_tready)
		else $error("input accepted during read-out");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(CAPACITY))
		else $error("list length beyond capacity");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata[1:0] == STAT_OK))
		else $error("empty marker without last flag");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && req == REQ_INSERT && full) |=>
		(m_axis_tvalid && m_axis_tdata[1:0] == STAT_FULL))
		else $error("insert into full list not reported");

endmodule
`default_nettype wire
